// ===== src/pmdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmdc_pkg
// shared types and register map of the pd motor duty controller
// ----------------------------------------------------------------------------
package pmdc_pkg;

    localparam int ErrW    = 16;
    localparam int GainW   = 16;
    localparam int DutyW   = 16;
    localparam int BoundW  = 15;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 16;

    // register map
    localparam logic [CfgIdxW-1:0] REG_P_GAIN      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_D_GAIN      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DUTY_BASE   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_INVERT_DIR  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ERROR_BOUND = 3'd4;

    typedef struct packed {
        logic [GainW-1:0]  p_gain;
        logic [GainW-1:0]  d_gain;
        logic [DutyW-1:0]  duty_base;
        logic              invert_direction;
        logic [BoundW-1:0] error_bound;
    } pmdc_cfg_t;

endpackage

// ===== src/pmdc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmdc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pmdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the contents from before a same-cycle write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/pmdc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmdc_cfg
// configuration register file
// ----------------------------------------------------------------------------
module pmdc_cfg
    import pmdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgDatW-1:0] cfg_data,
    output pmdc_cfg_t          cfg
);

    pmdc_cfg_t cfg_reg;
    pmdc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_P_GAIN:      cfg_next.p_gain           = cfg_data;
                REG_D_GAIN:      cfg_next.d_gain           = cfg_data;
                REG_DUTY_BASE:   cfg_next.duty_base        = cfg_data;
                REG_INVERT_DIR:  cfg_next.invert_direction = cfg_data[0];
                REG_ERROR_BOUND: cfg_next.error_bound      = cfg_data[BoundW-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/pmdc_history.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmdc_history
// ring of past errors; returns the oldest entry in the cycle after a request
// ----------------------------------------------------------------------------
module pmdc_history
    import pmdc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [ErrW-1:0] push_data,
    output logic [ErrW-1:0] oldest
);

    localparam int PtrW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FillW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [PtrW-1:0]  PtrLast = PtrW'(HISTORY_DEPTH - 1);
    localparam logic [FillW-1:0] FillFull = FillW'(HISTORY_DEPTH);

    logic [PtrW-1:0]  ptr_reg;
    logic [PtrW-1:0]  ptr_next;
    logic [FillW-1:0] fill_reg;
    logic [FillW-1:0] fill_next;
    logic             full_reg;
    logic [ErrW-1:0]  rd_data;

    // the new error goes into the slot of the oldest one in the same cycle
    pmdc_ram #(
        .WIDTH  (ErrW),
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (PtrW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (ptr_reg),
        .wr_data (push_data),
        .rd_en   (push),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        ptr_next  = ptr_reg;
        fill_next = fill_reg;
        if (push)
        begin
            ptr_next = (ptr_reg == PtrLast) ? '0 : ptr_reg + 1'b1;
            if (fill_reg != FillFull)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            fill_reg <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
            if (push)
            begin
                full_reg <= (fill_reg == FillFull);
            end
        end
    end

    // slots never written read as the reset value of zero
    assign oldest = full_reg ? rd_data : '0;

endmodule

// ===== src/pd_motor_duty_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_motor_duty_controller
// proportional-derivative duty controller for one motor joint
// ----------------------------------------------------------------------------
// Takes one signed angle error per request and returns one duty magnitude,
// direction and settled flag per request. The block is a three-register
// pipeline: input register with the history ring read, product register
// (the two gain multiplies), result register (sum, magnitude, shift and
// clamp). A new request is taken every clock cycle while the input is not
// stalled. A stage advances whenever the one after it is empty or moving
// on, so gaps close up and the input stalls only once all three stages
// hold requests behind a waiting result. The history ring is a ram written
// and read once per request; unwritten slots read as zero through a fill
// count, so no clearing pass follows reset.
// Configuration writes complete in the cycle they are presented.
module pd_motor_duty_controller
    import pmdc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgDatW-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [ErrW-1:0] angle_error,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DutyW-1:0]   duty_magnitude,
    output logic               clockwise,
    output logic               settled
);

    localparam int PW = 32;
    localparam int DW = 33;
    localparam int SW = 34;

    pmdc_cfg_t cfg;
    logic [ErrW-1:0] oldest;
    logic            in_accept;

    // stage 1
    logic                   s1_valid_reg;
    logic signed [ErrW-1:0] e_s1_reg;
    logic                   s1_ready;

    // stage 2
    logic                 s2_valid_reg;
    logic signed [PW-1:0] p_prod_reg;
    logic signed [DW-1:0] d_prod_reg;
    logic                 cw_s2_reg;
    logic                 settled_s2_reg;
    logic                 s2_ready;
    logic signed [PW-1:0] p_prod_next;
    logic signed [DW-1:0] d_prod_next;
    logic signed [ErrW:0] de;
    logic [ErrW-1:0]      abs_e;
    logic                 cw_next;
    logic                 settled_next;

    // stage 3
    logic                 s3_valid_reg;
    logic [DutyW-1:0]     duty_reg;
    logic                 cw_s3_reg;
    logic                 settled_s3_reg;
    logic                 s3_ready;
    logic signed [SW-1:0] sum;
    logic [SW-1:0]        mag;
    logic [SW-9:0]        mag_shift;
    logic [DutyW-1:0]     limit;
    logic [DutyW-1:0]     duty_next;

    pmdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pmdc_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (angle_error),
        .oldest    (oldest)
    );

    // handshake chain
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign in_accept = in_valid && in_ready;

    // stage 1 to 2: difference, products, direction and settled flag
    always_comb
    begin
        de = {e_s1_reg[ErrW-1], e_s1_reg} - {oldest[ErrW-1], oldest};
        p_prod_next = signed'({{(PW-GainW){1'b0}}, cfg.p_gain})
                    * signed'({{(PW-ErrW){e_s1_reg[ErrW-1]}}, e_s1_reg});
        d_prod_next = signed'({{(DW-GainW){1'b0}}, cfg.d_gain})
                    * signed'({{(DW-ErrW-1){de[ErrW]}}, de});
        abs_e = e_s1_reg[ErrW-1] ? ErrW'(-e_s1_reg) : e_s1_reg;
        settled_next = (abs_e <= {1'b0, cfg.error_bound});
        if (cfg.invert_direction)
        begin
            cw_next = e_s1_reg[ErrW-1];
        end
        else
        begin
            cw_next = !e_s1_reg[ErrW-1] && (e_s1_reg != '0);
        end
    end

    // stage 2 to 3: sum, magnitude, truncating shift, clamp
    always_comb
    begin
        sum = {{(SW-PW){p_prod_reg[PW-1]}}, p_prod_reg}
            + {{(SW-DW){d_prod_reg[DW-1]}}, d_prod_reg};
        mag = sum[SW-1] ? SW'(-sum) : sum;
        mag_shift = mag[SW-1:8];
        limit = 16'hFFFF - cfg.duty_base;
        if (mag_shift > {{(SW-8-DutyW){1'b0}}, limit})
        begin
            duty_next = limit;
        end
        else
        begin
            duty_next = mag_shift[DutyW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            e_s1_reg <= angle_error;
        end
        if (s2_ready && s1_valid_reg)
        begin
            p_prod_reg     <= p_prod_next;
            d_prod_reg     <= d_prod_next;
            cw_s2_reg      <= cw_next;
            settled_s2_reg <= settled_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            duty_reg       <= duty_next;
            cw_s3_reg      <= cw_s2_reg;
            settled_s3_reg <= settled_s2_reg;
        end
    end

    assign out_valid      = s3_valid_reg;
    assign duty_magnitude = duty_reg;
    assign clockwise      = cw_s3_reg;
    assign settled        = settled_s3_reg;

endmodule
